// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the tile binner.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define TBOB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define TBOB_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);
`else
`define TBOB_ASSERT(lbl, clk, rstn, prop, msg)
`define TBOB_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

// File: rtl/tbob_pkg.sv
// Shared types and constants of the tile bounding-box binner.
// No dependencies.
package tbob_pkg;

  localparam int unsigned MASK_W    = 32;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    TBL_WINDOW  = 1'b0,
    TBL_SCISSOR = 1'b1
  } tbl_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCISSOR_EN  = 2'd0,
    CFG_WIN_COUNT   = 2'd1,
    CFG_SCI_COUNT   = 2'd2
  } cfg_idx_e;

  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]   seg_idx_t;

endpackage

// File: rtl/tbob_in_if.sv
// Request channel into the binner: load or test command with its rectangle.
// Depends on tbob_pkg for field widths.
interface tbob_in_if #(
  parameter int unsigned CoordWidth = 24
);
  import tbob_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         command;
  logic                         table_select;
  seg_idx_t                     segment_index;
  logic signed [CoordWidth-1:0] x_min;
  logic signed [CoordWidth-1:0] y_min;
  logic signed [CoordWidth-1:0] x_max;
  logic signed [CoordWidth-1:0] y_max;
  logic                         last_in_batch;

  modport source (
    output valid, command, table_select, segment_index,
           x_min, y_min, x_max, y_max, last_in_batch,
    input  ready
  );

  modport sink (
    input  valid, command, table_select, segment_index,
           x_min, y_min, x_max, y_max, last_in_batch,
    output ready
  );
endinterface

// File: rtl/tbob_out_if.sv
// Result channel out of the binner: overlap and sticky batch masks.
// Depends on tbob_pkg for the mask type.
interface tbob_out_if;
  import tbob_pkg::*;

  logic  valid;
  logic  ready;
  mask_t overlap_mask;
  mask_t hit_any_mask;
  logic  batch_end;

  modport source (
    output valid, overlap_mask, hit_any_mask, batch_end,
    input  ready
  );

  modport sink (
    input  valid, overlap_mask, hit_any_mask, batch_end,
    output ready
  );
endinterface

// File: rtl/tbob_seg_table.sv
// One segment table: per-segment rectangle registers and the parallel
// strict overlap compare of a box against every entry. Self-contained.
module tbob_seg_table #(
  parameter int unsigned MaxSegments = 32,
  parameter int unsigned CoordWidth  = 24
) (
  input  logic                         clk_i,
  input  logic [MaxSegments-1:0]       we_i,
  input  logic signed [CoordWidth-1:0] x_min_i,
  input  logic signed [CoordWidth-1:0] y_min_i,
  input  logic signed [CoordWidth-1:0] x_max_i,
  input  logic signed [CoordWidth-1:0] y_max_i,
  output logic [MaxSegments-1:0]       hit_o
);

  logic signed [CoordWidth-1:0] lo_x_q [MaxSegments];
  logic signed [CoordWidth-1:0] lo_y_q [MaxSegments];
  logic signed [CoordWidth-1:0] hi_x_q [MaxSegments];
  logic signed [CoordWidth-1:0] hi_y_q [MaxSegments];

  // Entries hold no reset value; a load writes all four corners at once.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < MaxSegments; s++) begin
      if (we_i[s]) begin
        lo_x_q[s] <= x_min_i;
        lo_y_q[s] <= y_min_i;
        hi_x_q[s] <= x_max_i;
        hi_y_q[s] <= y_max_i;
      end
    end
  end

  always_comb begin
    for (int s = 0; s < MaxSegments; s++) begin
      hit_o[s] = (x_min_i < hi_x_q[s]) && (y_min_i < hi_y_q[s]) &&
                 (x_max_i > lo_x_q[s]) && (y_max_i > lo_y_q[s]);
    end
  end

endmodule

// File: rtl/tile_bbox_overlap_binner.sv
// Tile binner: a load request writes one rectangle into the window or the
// scissor segment table; a test request compares its box against every
// active segment of the table picked by scissor_enable and returns one
// overlap bit per segment plus the sticky hit mask of the batch, cleared
// after the result marked batch_end. One request is taken every cycle
// while the input is not stalled. A test waits in the input register
// while all segment compares run in parallel, then loads the result
// register. A held result stalls a waiting test and through it the
// input; loads pass. Loads produce no result. Depends on tbob_pkg,
// tbob_in_if, tbob_out_if, tbob_seg_table and assert_macros.svh.
`include "assert_macros.svh"

module tile_bbox_overlap_binner #(
  parameter int unsigned MAX_SEGMENTS = 32,
  parameter int unsigned COORD_WIDTH  = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tbob_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tbob_pkg::COUNT_W-1:0]     cfg_data_i,
  tbob_in_if.sink                          in_ch,
  tbob_out_if.source                       out_ch
);
  import tbob_pkg::*;

  // configuration
  logic   scissor_en_q;
  count_t win_count_q, sci_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scissor_en_q <= 1'b0;
      win_count_q  <= '0;
      sci_count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCISSOR_EN: scissor_en_q <= cfg_data_i[0];
        CFG_WIN_COUNT:  win_count_q  <= cfg_data_i;
        CFG_SCI_COUNT:  sci_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                          s1_valid_q;
  cmd_e                          s1_cmd_q;
  tbl_e                          s1_tbl_q;
  seg_idx_t                      s1_idx_q;
  logic signed [COORD_WIDTH-1:0] s1_x_min_q, s1_y_min_q, s1_x_max_q, s1_y_max_q;
  logic                          s1_last_q;

  logic out_valid_q;
  logic s1_go, in_fire, res_load;

  // a test in stage 1 waits only while the result register is held
  assign s1_go    = (s1_cmd_q != CMD_TEST) || !out_valid_q || out_ch.ready;
  assign in_ch.ready = !s1_valid_q || s1_go;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign res_load = s1_valid_q && (s1_cmd_q == CMD_TEST) &&
                    (!out_valid_q || out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q   <= cmd_e'(in_ch.command);
      s1_tbl_q   <= tbl_e'(in_ch.table_select);
      s1_idx_q   <= in_ch.segment_index;
      s1_x_min_q <= in_ch.x_min;
      s1_y_min_q <= in_ch.y_min;
      s1_x_max_q <= in_ch.x_max;
      s1_y_max_q <= in_ch.y_max;
      s1_last_q  <= in_ch.last_in_batch;
    end
  end

  // table write decode; an index at or above MAX_SEGMENTS matches nothing
  logic [MAX_SEGMENTS-1:0] win_we, sci_we, win_hit, sci_hit;
  logic                    s1_load;

  assign s1_load = s1_valid_q && (s1_cmd_q == CMD_LOAD);

  always_comb begin
    for (int s = 0; s < MAX_SEGMENTS; s++) begin
      win_we[s] = s1_load && (s1_tbl_q == TBL_WINDOW)  && (s1_idx_q == IDX_W'(s));
      sci_we[s] = s1_load && (s1_tbl_q == TBL_SCISSOR) && (s1_idx_q == IDX_W'(s));
    end
  end

  tbob_seg_table #(
    .MaxSegments(MAX_SEGMENTS),
    .CoordWidth (COORD_WIDTH)
  ) u_win_table (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .x_min_i(s1_x_min_q),
    .y_min_i(s1_y_min_q),
    .x_max_i(s1_x_max_q),
    .y_max_i(s1_y_max_q),
    .hit_o  (win_hit)
  );

  tbob_seg_table #(
    .MaxSegments(MAX_SEGMENTS),
    .CoordWidth (COORD_WIDTH)
  ) u_sci_table (
    .clk_i  (clk_i),
    .we_i   (sci_we),
    .x_min_i(s1_x_min_q),
    .y_min_i(s1_y_min_q),
    .x_max_i(s1_x_max_q),
    .y_max_i(s1_y_max_q),
    .hit_o  (sci_hit)
  );

  // mask to the active segments; counts above MAX_SEGMENTS enable all
  count_t count;
  mask_t  mask, hits_new;

  assign count = scissor_en_q ? sci_count_q : win_count_q;

  always_comb begin
    mask = '0;
    for (int s = 0; s < MAX_SEGMENTS; s++) begin
      mask[s] = (scissor_en_q ? sci_hit[s] : win_hit[s]) && (COUNT_W'(s) < count);
    end
  end

  // result register and sticky batch mask
  mask_t batch_hits_q;
  mask_t out_mask_q, out_hits_q;
  logic  out_end_q;

  assign hits_new = batch_hits_q | mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      batch_hits_q <= '0;
    end else begin
      if (res_load) begin
        out_valid_q  <= 1'b1;
        batch_hits_q <= s1_last_q ? '0 : hits_new;
      end else if (out_ch.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_mask_q <= mask;
      out_hits_q <= hits_new;
      out_end_q  <= s1_last_q;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.overlap_mask = out_mask_q;
  assign out_ch.hit_any_mask = out_hits_q;
  assign out_ch.batch_end    = out_end_q;

  // checks
  `TBOB_ASSERT(a_rise_from_test, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(s1_valid_q && (s1_cmd_q == CMD_TEST)),
    "result appeared without a test request")
  `TBOB_ASSERT_NEXT(a_batch_clear, clk_i, rst_ni, res_load && s1_last_q,
    batch_hits_q == '0, "sticky mask not cleared at batch end")
  `TBOB_ASSERT(a_mask_in_hits, clk_i, rst_ni,
    out_valid_q |-> ((out_mask_q & ~out_hits_q) == '0),
    "overlap bit missing from sticky mask")
  `TBOB_ASSERT(a_stall_cause, clk_i, rst_ni,
    !in_ch.ready |-> (s1_valid_q && out_valid_q && !out_ch.ready),
    "input stalled without a held result")

endmodule
